// ----- src/skle_pkg.sv -----
// Shared types and codes for the sorted key list engine.
`default_nettype none
package skle_pkg;

	// Operation codes on the input channel
	localparam logic [1:0] OP_INSERT  = 2'd0;
	localparam logic [1:0] OP_REM_MIN = 2'd1;
	localparam logic [1:0] OP_REM_MAX = 2'd2;

	// Result status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_FULL_NOW = 3'd1;
	localparam logic [2:0] ST_EMPTY    = 3'd2;
	localparam logic [2:0] ST_DUP      = 3'd3;
	localparam logic [2:0] ST_FULL_REJ = 3'd4;

	localparam int unsigned COUNT_OUT_BITS = 7;

	// Broadcast update command to every cell
	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_INSERT,
		CMD_REM_MIN,
		CMD_REM_MAX
	} cell_cmd_t;

	// Sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_APPLY
	} state_t;

endpackage
`default_nettype wire

// ----- src/skle_cell.sv -----
// One slot of the sorted row: holds a key, its valid bit and compare flags.
`default_nettype none
module skle_cell #(
	parameter int unsigned KEY_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cmp_en,
	input  wire skle_pkg::cell_cmd_t   cmd,
	input  wire logic [KEY_BITS-1:0]   bcast_key,
	input  wire logic [KEY_BITS-1:0]   left_key,
	input  wire logic                  left_valid,
	input  wire logic                  left_gt,
	input  wire logic [KEY_BITS-1:0]   right_key,
	input  wire logic                  right_valid,
	output logic [KEY_BITS-1:0]        key,
	output logic                       valid,
	output logic                       gt,
	output logic                       eq,
	output logic [KEY_BITS-1:0]        tail_key
);
	import skle_pkg::*;

	logic [KEY_BITS-1:0] key_q;
	logic                valid_q;
	logic                gt_q;
	logic                eq_q;
	logic [KEY_BITS-1:0] key_d;
	logic                valid_d;

	// Next content: shift right on insert, left on min removal, trim on max removal
	always_comb begin
		key_d   = key_q;
		valid_d = valid_q;
		case (cmd)
			CMD_INSERT: begin
				if (gt_q) begin
					key_d = left_gt ? left_key : bcast_key;
				end
				valid_d = valid_q | left_valid;
			end
			CMD_REM_MIN: begin
				key_d   = right_key;
				valid_d = right_valid;
			end
			CMD_REM_MAX: begin
				valid_d = valid_q & right_valid;
			end
			default: begin
				key_d   = key_q;
				valid_d = valid_q;
			end
		endcase
	end

	// Key storage needs no reset; valid does
	always_ff @(posedge clk) begin
		key_q <= key_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			gt_q    <= 1'b0;
			eq_q    <= 1'b0;
		end else begin
			valid_q <= valid_d;
			// empty slots count as larger than any key
			if (cmp_en) begin
				gt_q <= !valid_q || (key_q > bcast_key);
				eq_q <= valid_q && (key_q == bcast_key);
			end
		end
	end

	assign key      = key_q;
	assign valid    = valid_q;
	assign gt       = gt_q;
	assign eq       = eq_q;
	assign tail_key = (valid_q && !right_valid) ? key_q : '0;

endmodule
`default_nettype wire

// ----- src/sorted_key_list_engine.sv -----
// Top level of the sorted key list engine: cell row, sequencer and result register.
//
// Double-ended priority queue over up to CAPACITY distinct keys kept in
// ascending order in a row of cells, slot 0 holding the smallest key.
// Input channel (in_valid/in_ready): operation and key. Insert shifts the
// larger keys one cell up; remove-min shifts the row down; remove-max
// clears the topmost occupied cell. Output channel (out_valid/out_ready):
// status, removed key and count after the step, exactly one per item.
// Each item passes through a compare state, where every cell compares its key
// against the broadcast key and registers the flags, and an update state,
// where the row updates and the result register loads. A new item is
// accepted in that update state, while the last item is still updating.
// out_valid rises once the update has loaded the result register.
// If the receiver stalls with a result still held, the update waits and
// input is not accepted until the held result is taken.
// Reset empties the row and clears the output valid at once; no clearing
// pass is needed.
`default_nettype none
module sorted_key_list_engine #(
	parameter int unsigned CAPACITY = 64,
	parameter int unsigned KEY_BITS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [1:0]          operation,
	input  wire logic [KEY_BITS-1:0] key,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [2:0]               status,
	output logic [KEY_BITS-1:0]      removed_key,
	output logic [6:0]               count
);
	import skle_pkg::*;

	localparam int unsigned CW = $clog2(CAPACITY + 1);

	state_t              state_q, state_d;
	logic [1:0]          op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [CW-1:0]       count_q, count_d;
	logic                out_valid_q;
	logic [2:0]          status_q, status_d;
	logic [KEY_BITS-1:0] removed_q, removed_d;
	logic                fire, accept, cmp_en;
	cell_cmd_t           cmd;

	logic [KEY_BITS-1:0] c_key  [CAPACITY];
	logic [KEY_BITS-1:0] c_tail [CAPACITY];
	logic [CAPACITY-1:0] c_valid, c_gt, c_eq;
	logic                dup, full, empty;
	logic [KEY_BITS-1:0] max_key;
	logic [CW+6:0]       count_ext;

	// Cell row
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [KEY_BITS-1:0] lk, rk;
		logic                lv, lg, rv;
		if (i == 0) begin : g_first
			assign lk = '0;
			assign lv = 1'b1;
			assign lg = 1'b0;
		end else begin : g_mid
			assign lk = c_key[i-1];
			assign lv = c_valid[i-1];
			assign lg = c_gt[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign rk = '0;
			assign rv = 1'b0;
		end else begin : g_inner
			assign rk = c_key[i+1];
			assign rv = c_valid[i+1];
		end
		skle_cell #(.KEY_BITS(KEY_BITS)) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmp_en      (cmp_en),
			.cmd         (cmd),
			.bcast_key   (key_q),
			.left_key    (lk),
			.left_valid  (lv),
			.left_gt     (lg),
			.right_key   (rk),
			.right_valid (rv),
			.key         (c_key[i]),
			.valid       (c_valid[i]),
			.gt          (c_gt[i]),
			.eq          (c_eq[i]),
			.tail_key    (c_tail[i])
		);
	end

	// Row-wide flags: duplicate hit, the topmost key, and full and empty from the count
	always_comb begin
		max_key = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			max_key = max_key | c_tail[i];
		end
	end
	assign dup   = |c_eq;
	assign full  = (count_q == CW'(CAPACITY));
	assign empty = (count_q == '0);

	assign cmp_en   = (state_q == S_CMP);
	assign fire     = (state_q == S_APPLY) && (!out_valid_q || out_ready);
	assign in_ready = (state_q == S_IDLE) || fire;
	assign accept   = in_valid && in_ready;

	// Sequencer and result computation
	always_comb begin
		state_d   = state_q;
		cmd       = CMD_HOLD;
		count_d   = count_q;
		status_d  = ST_OK;
		removed_d = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_CMP;
			end
			S_CMP: begin
				state_d = S_APPLY;
			end
			S_APPLY: begin
				if (fire) begin
					state_d = accept ? S_CMP : S_IDLE;
					case (op_q)
						OP_INSERT: begin
							if (full) begin
								status_d = ST_FULL_REJ;
							end else if (dup) begin
								status_d = ST_DUP;
							end else begin
								cmd      = CMD_INSERT;
								count_d  = count_q + 1'b1;
								status_d = (count_d == CW'(CAPACITY)) ? ST_FULL_NOW : ST_OK;
							end
						end
						OP_REM_MIN: begin
							if (empty) begin
								status_d = ST_EMPTY;
							end else begin
								cmd       = CMD_REM_MIN;
								count_d   = count_q - 1'b1;
								removed_d = c_key[0];
							end
						end
						OP_REM_MAX: begin
							if (empty) begin
								status_d = ST_EMPTY;
							end else begin
								cmd       = CMD_REM_MAX;
								count_d   = count_q - 1'b1;
								removed_d = max_key;
							end
						end
						default: begin
							status_d = ST_OK;
						end
					endcase
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item capture and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= operation;
			key_q <= key;
		end
		if (fire) begin
			status_q  <= status_d;
			removed_q <= removed_d;
		end
	end

	logic [CW-1:0] count_out_q;
	always_ff @(posedge clk) begin
		if (fire) count_out_q <= count_d;
	end

	assign count_ext   = {7'd0, count_out_q};
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign removed_key = removed_q;
	assign count       = count_ext[COUNT_OUT_BITS-1:0];

	// Checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("key count above capacity");

	a_row_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		c_valid[0] == (count_q != '0))
		else $error("bottom cell occupancy disagrees with count");

	a_accept_to_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_CMP)
		else $error("accepted item did not enter compare cycle");

	a_apply_follows_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |=> state_q == S_APPLY)
		else $error("compare cycle not followed by update");

	a_fire_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("update did not present a result");

endmodule
`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking testbench for the sorted key list engine: directed table, then random traffic.
`timescale 1ns / 1ps
module tb;
	import skle_pkg::*;

	localparam int unsigned CAPACITY = 64;
	localparam int unsigned KEY_BITS = 16;
	localparam logic [1:0]  OP_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 900;
	localparam int PHASE_ITEMS = 120;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_AFTER_RESULTS = 300;
	localparam int HOLD_CYCLES = 400;

	// one result item as the block reports it
	typedef struct packed {
		logic [2:0]          status;
		logic [KEY_BITS-1:0] removed_key;
		logic [6:0]          count;
	} result_t;

	// one row of the directed table
	typedef struct packed {
		logic [1:0]          op;
		logic [KEY_BITS-1:0] key;
		logic                typed;
		result_t             want;
	} stim_row_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [1:0]          operation;
	logic [KEY_BITS-1:0] key;
	logic                out_valid;
	logic                out_ready;
	logic [2:0]          status;
	logic [KEY_BITS-1:0] removed_key;
	logic [6:0]          count;

	logic [KEY_BITS-1:0] held_keys[$];
	result_t             pending_results[$];
	stim_row_t           directed_rows[$];
	int                  errors = 0;
	int                  burst_left = 0;
	int                  cycle_count = 0;

	sorted_key_list_engine #(
		.CAPACITY(CAPACITY),
		.KEY_BITS(KEY_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.key(key),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.removed_key(removed_key),
		.count(count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Sorted set of held keys; applies one operation and returns its result
	function automatic result_t apply_to_held_keys(input logic [1:0] op,
			input logic [KEY_BITS-1:0] k);
		result_t r;
		int pos;
		r.status = ST_OK;
		r.removed_key = '0;
		case (op)
			OP_INSERT: begin
				pos = 0;
				while (pos < held_keys.size() && held_keys[pos] < k)
					pos++;
				if (held_keys.size() >= CAPACITY)
					r.status = ST_FULL_REJ;
				else if (pos < held_keys.size() && held_keys[pos] == k)
					r.status = ST_DUP;
				else begin
					held_keys.insert(pos, k);
					r.status = (held_keys.size() == CAPACITY) ? ST_FULL_NOW : ST_OK;
				end
			end
			OP_REM_MIN: begin
				if (held_keys.size() == 0)
					r.status = ST_EMPTY;
				else
					r.removed_key = held_keys.pop_front();
			end
			OP_REM_MAX: begin
				if (held_keys.size() == 0)
					r.status = ST_EMPTY;
				else
					r.removed_key = held_keys.pop_back();
			end
			default: ;
		endcase
		r.count = 7'(held_keys.size());
		return r;
	endfunction

	task automatic add_row(input logic [1:0] op, input logic [KEY_BITS-1:0] k,
			input logic typed, input logic [2:0] st, input logic [KEY_BITS-1:0] rk,
			input logic [6:0] cnt);
		stim_row_t row;
		row.op = op;
		row.key = k;
		row.typed = typed;
		row.want.status = st;
		row.want.removed_key = rk;
		row.want.count = cnt;
		directed_rows.push_back(row);
	endtask

	// Offer one item in bursts with random gaps; record its expectation on acceptance
	task automatic send_item(input logic [1:0] op, input logic [KEY_BITS-1:0] k,
			input logic typed, input result_t want);
		int gap;
		result_t predicted;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 10);
			burst_left = $urandom_range(1, 30);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		operation <= op;
		key <= k;
		do @(posedge clk); while (!in_ready);
		predicted = apply_to_held_keys(op, k);
		pending_results.push_back(typed ? want : predicted);
	endtask

	// Sender: reset, directed table, then phased random traffic
	initial begin : sender
		int n;
		int r;
		int phase;
		logic [1:0] op;
		logic [KEY_BITS-1:0] k;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		operation <= OP_INSERT;
		key <= '0;

		// empty-list cases, extremes, duplicates, unused code
		add_row(OP_REM_MIN, 16'h1234, 1'b1, ST_EMPTY, 16'h0000, 7'd0);
		add_row(OP_REM_MAX, 16'hFFFF, 1'b1, ST_EMPTY, 16'h0000, 7'd0);
		add_row(OP_UNUSED,  16'hFFFF, 1'b1, ST_OK,    16'h0000, 7'd0);
		add_row(OP_INSERT,  16'h0000, 1'b1, ST_OK,    16'h0000, 7'd1);
		add_row(OP_INSERT,  16'hFFFF, 1'b1, ST_OK,    16'h0000, 7'd2);
		add_row(OP_INSERT,  16'h0000, 1'b1, ST_DUP,   16'h0000, 7'd2);
		add_row(OP_INSERT,  16'hFFFF, 1'b1, ST_DUP,   16'h0000, 7'd2);
		add_row(OP_INSERT,  16'h8000, 1'b1, ST_OK,    16'h0000, 7'd3);
		add_row(OP_INSERT,  16'h7FFF, 1'b1, ST_OK,    16'h0000, 7'd4);
		add_row(OP_INSERT,  16'h5555, 1'b0, ST_OK,    16'h0000, 7'd0);
		add_row(OP_INSERT,  16'hAAAA, 1'b0, ST_OK,    16'h0000, 7'd0);
		add_row(OP_INSERT,  16'h0001, 1'b0, ST_OK,    16'h0000, 7'd0);
		add_row(OP_REM_MAX, 16'h1234, 1'b1, ST_OK,    16'hFFFF, 7'd6);
		add_row(OP_REM_MIN, 16'hFFFF, 1'b1, ST_OK,    16'h0000, 7'd5);
		add_row(OP_UNUSED,  16'h0000, 1'b0, ST_OK,    16'h0000, 7'd0);
		add_row(OP_REM_MIN, 16'h0000, 1'b0, ST_OK,    16'h0000, 7'd0);
		add_row(OP_REM_MAX, 16'h0000, 1'b0, ST_OK,    16'h0000, 7'd0);
		add_row(OP_INSERT,  16'hFFFE, 1'b0, ST_OK,    16'h0000, 7'd0);
		add_row(OP_INSERT,  16'h0000, 1'b0, ST_OK,    16'h0000, 7'd0);
		add_row(OP_REM_MIN, 16'h5A5A, 1'b0, ST_OK,    16'h0000, 7'd0);
		add_row(OP_REM_MAX, 16'hA5A5, 1'b0, ST_OK,    16'h0000, 7'd0);
		add_row(OP_REM_MIN, 16'h0000, 1'b0, ST_OK,    16'h0000, 7'd0);
		add_row(OP_REM_MAX, 16'h0000, 1'b0, ST_OK,    16'h0000, 7'd0);
		add_row(OP_REM_MIN, 16'h0000, 1'b0, ST_OK,    16'h0000, 7'd0);
		add_row(OP_REM_MIN, 16'hFFFF, 1'b1, ST_EMPTY, 16'h0000, 7'd0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_item(directed_rows[i].op, directed_rows[i].key,
				directed_rows[i].typed, directed_rows[i].want);

		// phases: fill toward full, mixed around the level reached, drain toward empty
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			phase = (n / PHASE_ITEMS) % 3;
			r = $urandom_range(0, 99);
			if (r < ((phase == 0) ? 92 : (phase == 1) ? 50 : 20))
				op = OP_INSERT;
			else if (r < 97)
				op = $urandom_range(0, 1) ? OP_REM_MIN : OP_REM_MAX;
			else
				op = OP_UNUSED;
			r = $urandom_range(0, 99);
			if (r < 10)
				k = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			else if (r < 25 && held_keys.size() != 0)
				k = held_keys[$urandom_range(0, held_keys.size() - 1)];
			else
				k = KEY_BITS'($urandom_range(0, 16'hFFFF));
			send_item(op, k, 1'b0, '0);
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Receiver: random stall modes, plus one long hold-off to back up the input
	initial begin : receiver
		int mode;
		int left;
		int taken;
		logic held_once;
		mode = 0;
		left = 0;
		taken = 0;
		held_once = 1'b0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				taken++;
			if (!held_once && taken >= HOLD_AFTER_RESULTS) begin
				held_once = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (left == 0) begin
				mode = $urandom_range(0, 2);
				left = $urandom_range(8, 80);
			end
			left--;
			case (mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 9) < 7);
				default: out_ready <= ($urandom_range(0, 9) < 3);
			endcase
		end
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: status %0d removed_key %0h count %0d",
					status, removed_key, count);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					errors++;
				end
				if (removed_key !== want.removed_key) begin
					$error("removed_key: expected %0h, got %0h", want.removed_key,
						removed_key);
					errors++;
				end
				if (count !== want.count) begin
					$error("count: expected %0d, got %0d", want.count, count);
					errors++;
				end
			end
		end
	end

	// Timeout guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

endmodule
